FILE: rtl/ekmf_pkg.sv
// ---------------------------------------------------------------------------
// ekmf_pkg
// Shared constants of the Edmonds-Karp maximum flow block.
// ---------------------------------------------------------------------------
package ekmf_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_ARCS_DEF  = 512;
  localparam int CAP_BITS_DEF  = 32;
  localparam int NODE_W        = 6;
  localparam int FLOW_W        = 40;
  localparam int CAP_IN_W      = 32;
  localparam int CFG_IDX_W     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 2'd2;

  // Input function codes.
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

endpackage

FILE: rtl/ekmf_ram.sv
// ---------------------------------------------------------------------------
// ekmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ekmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/edmonds_karp_max_flow.sv
// ---------------------------------------------------------------------------
// edmonds_karp_max_flow
// Maximum flow engine over a residual arc store, found by repeated BFS.
// ---------------------------------------------------------------------------
// After reset the engine nulls the node lists, and in_tready stays low
// meanwhile. An edge transaction (func 0) that is stored keeps the engine
// busy in states S_E1 to S_E4 after its acceptance. In those states two arcs
// are written, and both arcs are appended to the lists of their tail nodes.
// The next transaction is taken once the engine is back in S_IDLE.
// A rejected edge only sets the sticky drop flag, and the next transaction
// can follow in the next cycle. A run transaction (func 1) repeats
// breadth-first searches from source_node. Each search first clears the
// visited marks and seeds the queue. It then takes nodes from the queue and
// scans each node's arc list arc by arc, until the sink is reached or the
// queue runs empty. Each path found is walked back from the sink once to find
// the bottleneck and once more to update the residuals. A degenerate run
// goes straight to the result. The result is registered into the output
// register, and the next transaction is taken once that result has been
// delivered. All arc, list and search state sits in RAMs with one write port,
// one read port and registered reads, and a small sequencer steps through
// them one word at a time, so the arc and path counts set the rate.
module edmonds_karp_max_flow #(
  parameter int MAX_NODES = ekmf_pkg::MAX_NODES_DEF,
  parameter int MAX_ARCS  = ekmf_pkg::MAX_ARCS_DEF,
  parameter int CAP_BITS  = ekmf_pkg::CAP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ekmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ekmf_pkg::NODE_W-1:0]    cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata from bit 0: from_node[6], to_node[6], capacity[32], zero pad[4]
  input  logic [47:0]                    in_tdata,
  // tuser: func
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata from bit 0: flow_added[40]
  output logic [39:0]                    out_tdata,
  // tuser: edges_dropped
  output logic                           out_tuser
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = $clog2(MAX_ARCS);
  localparam int PW = AW + 1;        // arc pointer with a null code
  localparam int QW = NW + 1;        // queue counters that reach MAX_NODES
  localparam int CW = CAP_BITS;
  localparam int FW = ekmf_pkg::FLOW_W;
  localparam int TW = ekmf_pkg::NODE_W;
  localparam int RW = NW + CW + AW;  // arc word: target, residual, partner
  localparam logic [PW-1:0] NULL_ARC  = PW'(MAX_ARCS);
  localparam logic [NW:0]   UNVISITED = {1'b1, {NW{1'b0}}};
  localparam logic [CW-1:0] CAP_MAX   = {CW{1'b1}};

  typedef enum logic [21:0] {
    S_INIT  = 22'h000001, S_IDLE = 22'h000002, S_E1   = 22'h000004,
    S_E2    = 22'h000008, S_E3   = 22'h000010, S_E4   = 22'h000020,
    S_CLR   = 22'h000040, S_SEED = 22'h000080, S_POP  = 22'h000100,
    S_POPW  = 22'h000200, S_FRST = 22'h000400, S_ARC  = 22'h000800,
    S_ARCW  = 22'h001000, S_CHK  = 22'h002000, S_MINA = 22'h004000,
    S_MINW  = 22'h008000, S_MINC = 22'h010000, S_UPA  = 22'h020000,
    S_UPW   = 22'h040000, S_UPF  = 22'h080000, S_UPR  = 22'h100000,
    S_OUT   = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  logic [TW-1:0] src_r, snk_r, hi_r;
  logic          drop_r;
  logic [PW-1:0] used_r;
  logic [FW-1:0] total_r;
  logic          out_v_r;
  logic [FW-1:0] out_d_r;

  // Working registers.
  logic [NW-1:0] e_from_r, e_to_r;
  logic [CW-1:0] e_cap_r, least_r;
  logic [PW-1:0] lk_r;
  logic          lk_null_r;
  logic [QW-1:0] qh_r, qt_r;
  logic [NW-1:0] u_r, v_r, par_r, clr_r;
  logic [PW-1:0] a_r;
  logic [AW-1:0] cur_r, mate_r;
  logic          hit_r;

  // Memory ports.
  logic          ar_we, nx_we, nd_we, pn_we, pa_we, q_we;
  logic [AW-1:0] ar_wa, ar_ra, nx_wa, nx_ra;
  logic [RW-1:0] ar_wd, ar_rd;
  logic [PW-1:0] nx_wd, nx_rd;
  logic [NW-1:0] nd_wa, nd_ra, pn_wa, pn_ra, pa_wa, pa_ra, q_wa, q_ra, q_wd, q_rd;
  logic [2*PW-1:0] nd_wd, nd_rd;
  logic [NW:0]   pn_wd, pn_rd;
  logic [AW-1:0] pa_wd, pa_rd;

  // Arc words and arc successor links.
  ekmf_ram #(.WIDTH(RW), .DEPTH(MAX_ARCS)) u_arcs (
    .clk(clk), .we(ar_we), .waddr(ar_wa), .wdata(ar_wd),
    .raddr(ar_ra), .rdata(ar_rd)
  );
  ekmf_ram #(.WIDTH(PW), .DEPTH(MAX_ARCS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .raddr(nx_ra), .rdata(nx_rd)
  );

  // Per-node list ends: {first arc, last arc}.
  ekmf_ram #(.WIDTH(2*PW), .DEPTH(MAX_NODES)) u_nodes (
    .clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd),
    .raddr(nd_ra), .rdata(nd_rd)
  );

  // Parent node (with an unvisited code), parent arc and search queue.
  ekmf_ram #(.WIDTH(NW+1), .DEPTH(MAX_NODES)) u_pnode (
    .clk(clk), .we(pn_we), .waddr(pn_wa), .wdata(pn_wd), .raddr(pn_ra), .rdata(pn_rd)
  );
  ekmf_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_parc (
    .clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(pa_ra), .rdata(pa_rd)
  );
  ekmf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );

  logic [NW-1:0] rd_tgt;
  logic [CW-1:0] rd_res;
  logic [AW-1:0] rd_par;
  assign {rd_tgt, rd_res, rd_par} = ar_rd;

  logic [PW-1:0] nd_first, nd_last;
  assign {nd_first, nd_last} = nd_rd;

  // Arc numbers of the edge being stored.
  logic [AW-1:0] fwd_a, rev_a;
  logic [PW-1:0] rev_p;
  assign fwd_a = used_r[AW-1:0];
  assign rev_a = fwd_a + AW'(1);
  assign rev_p = used_r + PW'(1);

  // Input field unpacking.
  logic [TW-1:0] f_from, f_to;
  logic [ekmf_pkg::CAP_IN_W-1:0] f_cap;
  assign f_from = in_tdata[5:0];
  assign f_to   = in_tdata[11:6];
  assign f_cap  = in_tdata[43:12];

  logic [NW-1:0] src_n, snk_n;
  assign src_n = NW'(src_r);
  assign snk_n = NW'(snk_r);

  logic in_acc, out_acc;
  assign in_tready  = (state_r == S_IDLE) && !out_v_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_v_r && out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = drop_r;

  logic edge_ok, run_ok, take_arc;
  assign edge_ok = (f_from <= hi_r) && (f_to <= hi_r) &&
                   (32'(f_from) < 32'(MAX_NODES)) && (32'(f_to) < 32'(MAX_NODES)) &&
                   (32'(used_r) + 32'd2 <= 32'(MAX_ARCS));
  assign run_ok  = (src_r != snk_r) && (src_r <= hi_r) && (snk_r <= hi_r) &&
                   (32'(src_r) < 32'(MAX_NODES)) && (32'(snk_r) < 32'(MAX_NODES));
  // An arc with residual left that leads to an unvisited node.
  assign take_arc = hit_r && pn_rd[NW];

  logic [CW-1:0] cap_sat;
  assign cap_sat = (CAP_BITS < ekmf_pkg::CAP_IN_W &&
                    (64'(f_cap) > 64'(CAP_MAX))) ? CAP_MAX : CW'(f_cap);

  logic [FW:0] sum_w;
  assign sum_w = {1'b0, total_r} + (FW+1)'(least_r);

  logic clr_last;
  assign clr_last = (32'(clr_r) == MAX_NODES - 1);

  // Sequencer next state and memory ports.
  always_comb begin
    state_nxt = state_r;
    ar_we = 1'b0; ar_wa = cur_r; ar_wd = '0; ar_ra = a_r[AW-1:0];
    nx_we = 1'b0; nx_wa = fwd_a; nx_wd = NULL_ARC; nx_ra = a_r[AW-1:0];
    nd_we = 1'b0; nd_wa = clr_r; nd_wd = {NULL_ARC, NULL_ARC}; nd_ra = e_from_r;
    pn_we = 1'b0; pn_wa = clr_r; pn_wd = UNVISITED; pn_ra = v_r;
    pa_we = 1'b0; pa_wa = v_r; pa_wd = cur_r; pa_ra = v_r;
    q_we = 1'b0; q_wa = qt_r[NW-1:0]; q_wd = v_r; q_ra = qh_r[NW-1:0];
    case (state_r)
      S_INIT: begin
        nd_we = 1'b1;
        if (clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ekmf_pkg::FUNC_EDGE) begin
            state_nxt = edge_ok ? S_E1 : S_IDLE;
          end else begin
            state_nxt = run_ok ? S_CLR : S_OUT;
          end
        end
      end
      S_E1: begin
        ar_we = 1'b1; ar_wa = fwd_a; ar_wd = {e_to_r, e_cap_r, rev_a};
        nx_we = 1'b1; nx_wa = fwd_a;
        nd_ra = e_from_r;
        state_nxt = S_E2;
      end
      S_E2: begin
        ar_we = 1'b1; ar_wa = rev_a; ar_wd = {e_from_r, {CW{1'b0}}, fwd_a};
        nx_we = 1'b1; nx_wa = rev_a;
        nd_we = 1'b1; nd_wa = e_from_r;
        nd_wd = {(nd_first == NULL_ARC) ? used_r : nd_first, used_r};
        state_nxt = S_E3;
      end
      S_E3: begin
        nx_we = !lk_null_r; nx_wa = lk_r[AW-1:0]; nx_wd = used_r;
        nd_ra = e_to_r;
        state_nxt = S_E4;
      end
      S_E4: begin
        nd_we = 1'b1; nd_wa = e_to_r;
        nd_wd = {(nd_first == NULL_ARC) ? rev_p : nd_first, rev_p};
        nx_we = (nd_first != NULL_ARC); nx_wa = nd_last[AW-1:0]; nx_wd = rev_p;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        pn_we = 1'b1;
        if (clr_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        pn_we = 1'b1; pn_wa = src_n; pn_wd = {1'b0, src_n};
        q_we = 1'b1; q_wa = '0; q_wd = src_n;
        state_nxt = S_POP;
      end
      S_POP: begin
        state_nxt = (qh_r < qt_r) ? S_POPW : S_OUT;
      end
      S_POPW: begin
        nd_ra = q_rd;
        state_nxt = S_FRST;
      end
      S_FRST: state_nxt = S_ARC;
      S_ARC: begin
        state_nxt = (a_r < used_r) ? S_ARCW : S_POP;
      end
      S_ARCW: begin
        pn_ra = rd_tgt;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_ARC;
        if (take_arc) begin
          pn_we = 1'b1; pn_wa = v_r; pn_wd = {1'b0, u_r};
          pa_we = 1'b1;
          if (v_r == snk_n) state_nxt = S_MINA;
          else q_we = (32'(qt_r) < MAX_NODES);
        end
      end
      S_MINA: state_nxt = S_MINW;
      S_MINW: begin ar_ra = pa_rd; state_nxt = S_MINC; end
      S_MINC: begin
        state_nxt = (par_r == src_n) ? S_UPA : S_MINA;
      end
      S_UPA: state_nxt = S_UPW;
      S_UPW: begin ar_ra = pa_rd; state_nxt = S_UPF; end
      S_UPF: begin
        ar_we = 1'b1; ar_wa = cur_r; ar_wd = {rd_tgt, rd_res - least_r, rd_par};
        ar_ra = rd_par;
        state_nxt = S_UPR;
      end
      S_UPR: begin
        ar_we = 1'b1; ar_wa = mate_r; ar_wd = {rd_tgt, rd_res + least_r, rd_par};
        state_nxt = (par_r == src_n) ? S_CLR : S_UPA;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      src_r <= '0; snk_r <= TW'(1); hi_r <= TW'(63);
      drop_r <= 1'b0; used_r <= '0; out_v_r <= 1'b0;
      clr_r <= '0; total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ekmf_pkg::CFG_SOURCE:  src_r <= cfg_wdata;
          ekmf_pkg::CFG_SINK:    snk_r <= cfg_wdata;
          ekmf_pkg::CFG_HIGHEST: hi_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_acc) out_v_r <= 1'b0;
      case (state_r)
        S_INIT, S_CLR: begin
          clr_r <= clr_last ? '0 : NW'(clr_r + NW'(1));
        end
        S_IDLE: begin
          if (in_acc) begin
            e_from_r <= NW'(f_from); e_to_r <= NW'(f_to);
            e_cap_r <= cap_sat; total_r <= '0;
            if (in_tuser == ekmf_pkg::FUNC_EDGE && !edge_ok) drop_r <= 1'b1;
          end
        end
        S_E2: begin
          // Remember the old tail of the from node's list.
          lk_r <= nd_last; lk_null_r <= (nd_first == NULL_ARC);
        end
        S_E4: used_r <= used_r + PW'(2);
        S_SEED: begin
          qh_r <= '0; qt_r <= QW'(1);
        end
        S_POP: if (qh_r < qt_r) qh_r <= qh_r + QW'(1);
        S_POPW: u_r <= q_rd;
        S_FRST: a_r <= nd_first;
        S_ARCW: begin
          v_r <= rd_tgt; hit_r <= (rd_res != '0);
          cur_r <= a_r[AW-1:0]; a_r <= nx_rd;
        end
        S_CHK: begin
          if (take_arc) begin
            if (v_r == snk_n) least_r <= CAP_MAX;
            else if (32'(qt_r) < MAX_NODES) qt_r <= qt_r + QW'(1);
          end
        end
        S_MINW, S_UPW: begin
          par_r <= pn_rd[NW-1:0]; cur_r <= pa_rd;
        end
        S_MINC: begin
          if (rd_res < least_r) least_r <= rd_res;
          v_r <= (par_r == src_n) ? snk_n : par_r;
        end
        S_UPF: mate_r <= rd_par;
        S_UPR: begin
          v_r <= par_r;
          if (par_r == src_n) begin
            total_r <= sum_w[FW] ? {FW{1'b1}} : sum_w[FW-1:0];
          end
        end
        S_OUT: begin
          out_v_r <= 1'b1; out_d_r <= total_r;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/tb_edmonds_karp_max_flow.sv
// ---------------------------------------------------------------------------
// tb_edmonds_karp_max_flow
// Self-checking testbench for the Edmonds-Karp maximum flow engine.
// ---------------------------------------------------------------------------
// Edge and run transactions are queued by a stimulus process and presented by
// a bursty driver. Every accepted transaction is applied to a behavioural flow
// model, which keeps its own residual graph. Each run transaction queues one
// expected result, and the monitor compares every delivered result against
// the oldest entry in that queue. The configuration is changed only between
// phases, once the engine has drained and settled.
// ---------------------------------------------------------------------------
module tb_edmonds_karp_max_flow;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NNODES    = 64;
  localparam int NARCS     = 512;
  localparam int NO_ARC    = NARCS;
  localparam int NOT_SEEN  = NNODES;
  localparam int IDLE_MAX  = 4000000;
  localparam int SETTLE    = 40;
  localparam logic [39:0] FLOW_SAT = 40'hFF_FFFF_FFFF;

  typedef struct {
    logic        func;
    logic [5:0]  from_n;
    logic [5:0]  to_n;
    logic [31:0] cap;
  } flow_req_t;

  typedef struct {
    logic [39:0] flow;
    logic        dropped;
  } flow_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  flow_req_t pending_reqs[$];
  flow_res_t expected_flows[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  logic      in_fire_q = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_mode = 0;
  int        stall_left = 0;

  // Behavioural copy of the residual graph and the configuration.
  logic [5:0]  g_src = 6'd0, g_snk = 6'd1, g_hi = 6'd63;
  logic [5:0]  g_target [NARCS];
  longint      g_resid  [NARCS];
  int          g_mate   [NARCS];
  int          g_next   [NARCS];
  int          g_head   [NNODES];
  int          g_tail   [NNODES];
  int          g_used = 0;
  logic        g_drop = 1'b0;
  int          bfs_par_node [NNODES];
  int          bfs_par_arc  [NNODES];

  edmonds_karp_max_flow u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Append an arc to the adjacency list of a node.
  function automatic void link_arc(int node, int arc);
    g_next[arc] = NO_ARC;
    if (g_head[node] == NO_ARC) begin
      g_head[node] = arc;
    end else begin
      g_next[g_tail[node]] = arc;
    end
    g_tail[node] = arc;
  endfunction

  // Store an edge as a forward and a zero-residual reverse arc, or drop it.
  function automatic void store_edge(logic [5:0] f, logic [5:0] t, logic [31:0] c);
    int fwd;
    if (f > g_hi || t > g_hi || g_used + 2 > NARCS) begin
      g_drop = 1'b1;
      return;
    end
    fwd = g_used;
    g_used += 2;
    g_target[fwd] = t;
    g_resid[fwd] = longint'(c);
    g_mate[fwd] = fwd + 1;
    g_target[fwd+1] = f;
    g_resid[fwd+1] = 0;
    g_mate[fwd+1] = fwd;
    link_arc(f, fwd);
    link_arc(t, fwd + 1);
  endfunction

  // Breadth-first search over arcs with residual left; stops at the sink.
  function automatic bit find_augmenting_path();
    int bq [NNODES];
    int qh, qt, u, a, v;
    qh = 0;
    qt = 0;
    for (int i = 0; i < NNODES; i++) bfs_par_node[i] = NOT_SEEN;
    bfs_par_node[g_src] = g_src;
    bq[qt++] = g_src;
    while (qh < qt) begin
      u = bq[qh++];
      a = g_head[u];
      while (a < g_used) begin
        v = g_target[a];
        if (g_resid[a] > 0 && bfs_par_node[v] == NOT_SEEN) begin
          bfs_par_node[v] = u;
          bfs_par_arc[v] = a;
          if (v == g_snk) return 1'b1;
          if (qt < NNODES) bq[qt++] = v;
        end
        a = g_next[a];
      end
    end
    return 1'b0;
  endfunction

  // Augment until no path is left and return the flow pushed by this run.
  function automatic logic [39:0] max_flow_increment();
    longint total, least;
    int v;
    total = 0;
    if (g_src == g_snk || g_src > g_hi || g_snk > g_hi) return '0;
    while (find_augmenting_path()) begin
      least = 64'hFFFF_FFFF;
      for (v = g_snk; v != g_src; v = bfs_par_node[v])
        if (g_resid[bfs_par_arc[v]] < least) least = g_resid[bfs_par_arc[v]];
      for (v = g_snk; v != g_src; v = bfs_par_node[v]) begin
        g_resid[bfs_par_arc[v]] -= least;
        g_resid[g_mate[bfs_par_arc[v]]] += least;
      end
      total += least;
      if (total > longint'(FLOW_SAT)) total = longint'(FLOW_SAT);
    end
    return total[39:0];
  endfunction

  function automatic flow_req_t mk_req(logic func, logic [5:0] f, logic [5:0] t,
                                       logic [31:0] c);
    flow_req_t r;
    r.func = func;
    r.from_n = f;
    r.to_n = t;
    r.cap = c;
    return r;
  endfunction

  // Add a transaction at the end of the pending queue.
  function automatic void queue_req(flow_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Mostly nodes in range, now and then any node index at all.
  function automatic logic [5:0] pick_node(int hi);
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, hi));
  endfunction

  function automatic logic [31:0] pick_cap();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return 32'($urandom_range(1, 20));
      default: return $urandom;
    endcase
  endfunction

  // Wait for the engine to drain, then let it settle.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_flows.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all three registers while the engine is idle.
  task automatic write_config(logic [5:0] src, logic [5:0] snk, logic [5:0] hi);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ekmf_pkg::CFG_SOURCE;
    cfg_wdata <= src;
    @(negedge clk);
    cfg_index <= ekmf_pkg::CFG_SINK;
    cfg_wdata <= snk;
    @(negedge clk);
    cfg_index <= ekmf_pkg::CFG_HIGHEST;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    g_src = src;
    g_snk = snk;
    g_hi = hi;
  endtask

  // Input driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    flow_req_t r;
    if (rst_n && (!in_tvalid || in_fire_q)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_tdata <= {4'b0, r.cap, r.to_n, r.from_n};
        in_tuser <= r.func;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure: switches between free-running, random and sparse.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Monitor: predicts on input transactions, checks output transactions.
  always @(posedge clk) begin
    flow_req_t r;
    flow_res_t e;
    if (rst_n) begin
      in_fire_q <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        r = mk_req(in_tuser, in_tdata[5:0], in_tdata[11:6], in_tdata[43:12]);
        if (r.func == ekmf_pkg::FUNC_EDGE) begin
          store_edge(r.from_n, r.to_n, r.cap);
        end else begin
          e.flow = max_flow_increment();
          e.dropped = g_drop;
          expected_flows.insert(expected_flows.size(), e);
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_flows.size() == 0) begin
          $error("unexpected result: flow_added %0d", out_tdata);
          fail_count++;
        end else begin
          e = expected_flows.pop_front();
          if (out_tdata !== e.flow) begin
            $error("flow_added: expected %0d, actual %0d", e.flow, out_tdata);
            fail_count++;
          end
          if (out_tuser !== e.dropped) begin
            $error("edges_dropped: expected %0d, actual %0d", e.dropped, out_tuser);
            fail_count++;
          end
        end
      end
      // Watchdog on cycles without any transaction.
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: directed cases first, then random phases.
  initial begin
    int hi, n_items;
    logic [5:0] src, snk;
    for (int i = 0; i < NNODES; i++) begin
      g_head[i] = NO_ARC;
      g_tail[i] = NO_ARC;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Small network with widest and zero capacities, a self loop, a run twice.
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd0, 6'd2, 32'hFFFF_FFFF));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd2, 6'd1, 32'd5));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd0, 6'd3, 32'd7));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd3, 6'd1, 32'd0));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd3, 6'd2, 32'd10));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd2, 6'd2, 32'd9));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd0, 6'd1, 32'd1));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd63, 6'd0, 32'd3));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd2, 6'd63, 32'd4));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd63, 6'd1, 32'd2));
    queue_req(mk_req(ekmf_pkg::FUNC_RUN, 6'd63, 6'd63, 32'hFFFF_FFFF));
    queue_req(mk_req(ekmf_pkg::FUNC_RUN, 6'd0, 6'd0, 32'd0));
    wait_drained();

    // Lowered node limit: out-of-range edges dropped, old arcs still used.
    write_config(6'd0, 6'd1, 6'd5);
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd6, 6'd1, 32'd8));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd1, 6'd63, 32'd8));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd3, 6'd1, 32'd6));
    queue_req(mk_req(ekmf_pkg::FUNC_RUN, 6'd0, 6'd0, 32'd0));
    wait_drained();

    // Degenerate runs: source equals sink, source above the node limit.
    write_config(6'd3, 6'd3, 6'd5);
    queue_req(mk_req(ekmf_pkg::FUNC_RUN, 6'd0, 6'd0, 32'd0));
    wait_drained();
    write_config(6'd63, 6'd1, 6'd1);
    queue_req(mk_req(ekmf_pkg::FUNC_RUN, 6'd0, 6'd0, 32'd0));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd0, 6'd2, 32'd1));
    queue_req(mk_req(ekmf_pkg::FUNC_EDGE, 6'd1, 6'd0, 32'd1));
    wait_drained();

    // Random phases, each with its own source, sink and node limit.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: hi = 63;
        1: hi = 1;
        default: hi = $urandom_range(2, 15);
      endcase
      src = 6'($urandom_range(0, hi));
      snk = 6'($urandom_range(0, hi));
      if ($urandom_range(0, 7) == 0) src = 6'($urandom_range(0, 63));
      write_config(src, snk, 6'(hi));
      n_items = 115;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 5) == 0)
          queue_req(mk_req(ekmf_pkg::FUNC_RUN, 6'($urandom), 6'($urandom), $urandom));
        else
          queue_req(mk_req(ekmf_pkg::FUNC_EDGE, pick_node(hi), pick_node(hi),
                           pick_cap()));
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: edmonds_karp_max_flow.f
rtl/ekmf_pkg.sv
rtl/ekmf_ram.sv
rtl/edmonds_karp_max_flow.sv
tb/tb_edmonds_karp_max_flow.sv
